@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, suspended while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/tzsd_pkg.sv @@
// ---------------------------------------------------------------------------
// tzsd_pkg
// Types and constants of the touch zone swipe detector.
// ---------------------------------------------------------------------------
package tzsd_pkg;

  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 8;
  localparam int TRAVEL_W  = 8;
  localparam int CFG_W     = 16;
  localparam int INTENS_W  = 2;

  localparam int IN_TDATA_W  = TIME_W + STATUS_W;  // 40, already whole bytes
  localparam int OUT_TDATA_W = 16;                 // 10 payload bits, padded

  localparam logic [TRAVEL_W-1:0] TRAVEL_MAX = 8'hFF;

  // reset values of the configuration registers
  localparam logic [15:0]         POLL_INTERVAL_RST = 16'd20;
  localparam logic [15:0]         IDLE_RESET_RST    = 16'd800;
  localparam logic [TRAVEL_W-1:0] TRAVEL_FIRE_RST   = 8'd4;

  typedef enum logic [1:0] {
    CFG_SENSOR_ENABLE = 2'd0,
    CFG_POLL_INTERVAL = 2'd1,
    CFG_IDLE_RESET    = 2'd2,
    CFG_TRAVEL_FIRE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TRAVEL_W-1:0] travel_now;
    logic                accepted;
    logic                swipe;
  } result_t;

endpackage

@@ src/tzsd_step.sv @@
// ---------------------------------------------------------------------------
// tzsd_step
// Combinational poll update: rate limit, zone decode, edges, travel, swipe.
// ---------------------------------------------------------------------------
module tzsd_step #(
  parameter int NUM_ZONES = 3,
  parameter int ZW        = 2
) (
  input  logic                            sensor_enable,
  input  logic [15:0]                     poll_interval_ms,
  input  logic [15:0]                     idle_reset_ms,
  input  logic [tzsd_pkg::TRAVEL_W-1:0]   travel_to_fire,
  input  logic [tzsd_pkg::TIME_W-1:0]     now_ms,
  input  logic [tzsd_pkg::STATUS_W-1:0]   status_byte,
  input  logic                            read_ok,
  input  logic [tzsd_pkg::TIME_W-1:0]     last_poll_time,
  input  logic [NUM_ZONES-1:0]            prev_touched,
  input  logic                            origin_valid,
  input  logic [ZW-1:0]                   origin_zone,
  input  logic [tzsd_pkg::TIME_W-1:0]     last_move_time,
  input  logic [tzsd_pkg::TRAVEL_W-1:0]   travel_count,
  output logic [tzsd_pkg::TIME_W-1:0]     last_poll_time_next,
  output logic [NUM_ZONES-1:0]            prev_touched_next,
  output logic                            origin_valid_next,
  output logic [ZW-1:0]                   origin_zone_next,
  output logic [tzsd_pkg::TIME_W-1:0]     last_move_time_next,
  output logic [tzsd_pkg::TRAVEL_W-1:0]   travel_count_next,
  output tzsd_pkg::result_t               result
);

  localparam int CW = $clog2(NUM_ZONES + 1);
  localparam int TW = tzsd_pkg::TRAVEL_W;

  logic [tzsd_pkg::TIME_W-1:0] poll_gap;
  logic [tzsd_pkg::TIME_W-1:0] move_gap;
  logic                        take;
  logic                        idle;
  logic [NUM_ZONES-1:0]        touched;
  logic [NUM_ZONES-1:0]        rises;
  logic [NUM_ZONES-1:0]        falls;
  logic [CW-1:0]               fall_steps;
  logic [CW-1:0]               rise_cnt;
  logic [ZW-1:0]               rose;
  logic [TW-1:0]               travel_base;
  logic [TW:0]                 travel_sum;
  logic [TW-1:0]               travel_fall;
  logic [TW-1:0]               travel_rise;
  logic [TW-1:0]               travel_fin;
  logic                        ov_base;
  logic                        adjacent;
  logic                        check;
  logic                        fire;
  logic                        left_t;
  logic                        right_t;

  assign poll_gap = now_ms - last_poll_time;
  assign move_gap = now_ms - last_move_time;
  assign take     = sensor_enable && (poll_gap >= {16'd0, poll_interval_ms});
  assign idle     = (travel_count != '0) && (move_gap > {16'd0, idle_reset_ms});

  always_comb begin
    touched = '0;
    for (int z = 0; z < NUM_ZONES; z++) begin
      touched[z] = |status_byte[2*(NUM_ZONES-1-z) +: tzsd_pkg::INTENS_W];
    end
  end

  assign rises    = touched & ~prev_touched;
  assign falls    = prev_touched & ~touched;
  assign rise_cnt = CW'($countones(rises));

  // a fall counts when a neighbor zone is still touched
  always_comb begin
    fall_steps = '0;
    for (int z = 0; z < NUM_ZONES; z++) begin
      left_t  = (z > 0) ? touched[(z > 0) ? z - 1 : 0] : 1'b0;
      right_t = (z + 1 < NUM_ZONES) ? touched[(z + 1 < NUM_ZONES) ? z + 1 : z] : 1'b0;
      if (falls[z] && (left_t || right_t)) begin
        fall_steps = fall_steps + CW'(1);
      end
    end
  end

  // highest rising zone
  always_comb begin
    rose = '0;
    for (int z = 0; z < NUM_ZONES; z++) begin
      if (rises[z]) begin
        rose = ZW'(z);
      end
    end
  end

  assign travel_base = idle ? '0 : travel_count;
  assign ov_base     = idle ? 1'b0 : origin_valid;
  assign travel_sum  = {1'b0, travel_base} + (TW+1)'(fall_steps);
  assign travel_fall = travel_sum[TW] ? tzsd_pkg::TRAVEL_MAX : travel_sum[TW-1:0];

  assign adjacent = ov_base &&
                    (({1'b0, rose} == {1'b0, origin_zone} + (ZW+1)'(1)) ||
                     ({1'b0, origin_zone} == {1'b0, rose} + (ZW+1)'(1)));

  always_comb begin
    travel_rise = travel_fall;
    if ((rise_cnt == CW'(1)) && adjacent && (travel_fall != tzsd_pkg::TRAVEL_MAX)) begin
      travel_rise = travel_fall + TW'(1);
    end
  end

  assign check = (rise_cnt <= CW'(1));
  assign fire  = check && (travel_rise >= travel_to_fire);
  assign travel_fin = fire ? '0 : travel_rise;

  always_comb begin
    last_poll_time_next = last_poll_time;
    prev_touched_next   = prev_touched;
    origin_valid_next   = origin_valid;
    origin_zone_next    = origin_zone;
    last_move_time_next = last_move_time;
    travel_count_next   = travel_count;
    result.swipe        = 1'b0;
    result.accepted     = 1'b0;
    result.travel_now   = travel_count;
    if (take) begin
      last_poll_time_next = now_ms;
      result.accepted     = 1'b1;
      if (read_ok) begin
        prev_touched_next = touched;
        travel_count_next = travel_fin;
        if ((fall_steps != '0) || (rise_cnt != '0)) begin
          last_move_time_next = now_ms;
        end
        origin_valid_next = ov_base;
        if (rise_cnt >= CW'(NUM_ZONES)) begin
          origin_valid_next = 1'b0;
        end else if (rise_cnt != '0) begin
          origin_valid_next = 1'b1;
          origin_zone_next  = rose;
        end
        if (fire) begin
          origin_valid_next = 1'b0;
        end
        result.swipe      = fire;
        result.travel_now = travel_fin;
      end
    end
  end

endmodule

@@ src/touch_zone_swipe_detector_top.sv @@
// A poll passes the input register and then the result register before it is valid
// on the master side; throughput is one poll per cycle while m_tready is high, a single
// pass of shallow logic between the input register and the result register.
// Backpressure on the master side holds both registers and drops s_tready once the
// input register holds a poll. Reset (rst, synchronous) empties both stages, clears
// gesture state and loads defaults: sensor off, 20 ms poll, 800 ms idle, 4 to fire.
// ---------------------------------------------------------------------------
// touch_zone_swipe_detector_top
// Rate limited poll processing of a touch strip into swipe events.
// ---------------------------------------------------------------------------
module touch_zone_swipe_detector_top #(
  parameter int NUM_ZONES = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_addr,
  input  logic [tzsd_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tzsd_pkg::IN_TDATA_W-1:0]   s_tdata,   // now_ms[31:0], status_byte[39:32]
  input  logic                              s_tuser,   // read_ok
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tzsd_pkg::OUT_TDATA_W-1:0]  m_tdata    // swipe[0], accepted[1], travel_now[9:2]
);

  `include "assert_macros.svh"

  localparam int ZW = (NUM_ZONES > 2) ? $clog2(NUM_ZONES) : 1;
  localparam int TW = tzsd_pkg::TIME_W;

  // configuration
  logic                          sensor_enable;
  logic [15:0]                   poll_interval_ms;
  logic [15:0]                   idle_reset_ms;
  logic [tzsd_pkg::TRAVEL_W-1:0] travel_to_fire;

  // input stage
  logic                          in_valid;
  logic [TW-1:0]                 in_now;
  logic [tzsd_pkg::STATUS_W-1:0] in_status;
  logic                          in_ok;

  // gesture state
  logic [TW-1:0]                 last_poll_time;
  logic [NUM_ZONES-1:0]          prev_touched;
  logic                          origin_valid;
  logic [ZW-1:0]                 origin_zone;
  logic [TW-1:0]                 last_move_time;
  logic [tzsd_pkg::TRAVEL_W-1:0] travel_count;

  logic [TW-1:0]                 last_poll_time_next;
  logic [NUM_ZONES-1:0]          prev_touched_next;
  logic                          origin_valid_next;
  logic [ZW-1:0]                 origin_zone_next;
  logic [TW-1:0]                 last_move_time_next;
  logic [tzsd_pkg::TRAVEL_W-1:0] travel_count_next;
  tzsd_pkg::result_t             step_res;

  // result stage
  logic                          out_valid;
  tzsd_pkg::result_t             out_res;

  logic                          advance;
  logic                          step_go;

  assign advance  = !out_valid || m_tready;
  assign step_go  = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_enable    <= 1'b0;
      poll_interval_ms <= tzsd_pkg::POLL_INTERVAL_RST;
      idle_reset_ms    <= tzsd_pkg::IDLE_RESET_RST;
      travel_to_fire   <= tzsd_pkg::TRAVEL_FIRE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        tzsd_pkg::CFG_SENSOR_ENABLE: sensor_enable    <= cfg_wdata[0];
        tzsd_pkg::CFG_POLL_INTERVAL: poll_interval_ms <= cfg_wdata;
        tzsd_pkg::CFG_IDLE_RESET:    idle_reset_ms    <= cfg_wdata;
        tzsd_pkg::CFG_TRAVEL_FIRE:   travel_to_fire   <= cfg_wdata[tzsd_pkg::TRAVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: load on each transfer, hold while the result stage stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_now    <= s_tdata[TW-1:0];
      in_status <= s_tdata[TW +: tzsd_pkg::STATUS_W];
      in_ok     <= s_tuser;
    end
  end

  tzsd_step #(
    .NUM_ZONES (NUM_ZONES),
    .ZW        (ZW)
  ) u_step (
    .sensor_enable       (sensor_enable),
    .poll_interval_ms    (poll_interval_ms),
    .idle_reset_ms       (idle_reset_ms),
    .travel_to_fire      (travel_to_fire),
    .now_ms              (in_now),
    .status_byte         (in_status),
    .read_ok             (in_ok),
    .last_poll_time      (last_poll_time),
    .prev_touched        (prev_touched),
    .origin_valid        (origin_valid),
    .origin_zone         (origin_zone),
    .last_move_time      (last_move_time),
    .travel_count        (travel_count),
    .last_poll_time_next (last_poll_time_next),
    .prev_touched_next   (prev_touched_next),
    .origin_valid_next   (origin_valid_next),
    .origin_zone_next    (origin_zone_next),
    .last_move_time_next (last_move_time_next),
    .travel_count_next   (travel_count_next),
    .result              (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_poll_time <= '0;
      prev_touched   <= '0;
      origin_valid   <= 1'b0;
      origin_zone    <= '0;
      last_move_time <= '0;
      travel_count   <= '0;
    end else if (step_go) begin
      last_poll_time <= last_poll_time_next;
      prev_touched   <= prev_touched_next;
      origin_valid   <= origin_valid_next;
      origin_zone    <= origin_zone_next;
      last_move_time <= last_move_time_next;
      travel_count   <= travel_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(tzsd_pkg::OUT_TDATA_W - $bits(tzsd_pkg::result_t)){1'b0}}, out_res};

  `ASSERT_CLK(a_swipe_clears_travel, clk, rst,
    (out_valid && out_res.swipe) |-> (out_res.travel_now == '0 && out_res.accepted),
    "swipe result without cleared travel or acceptance")
  `ASSERT_CLK(a_rejected_poll_keeps_state, clk, rst,
    (step_go && !step_res.accepted) |=> ($stable(last_poll_time) && $stable(travel_count)),
    "rejected poll changed gesture state")
  `ASSERT_CLK(a_held_input_stays, clk, rst,
    (in_valid && !advance) |=> (in_valid && $stable(in_now) && $stable(in_status)),
    "stalled input stage lost or changed its poll")
  `ASSERT_ALWAYS(a_reset_empties_output, clk,
    rst |=> (!out_valid && !in_valid),
    "pipeline not empty after reset")

endmodule
